@@ rtl/core/hfd_pkg.sv @@
// Package: shared types and constants for the heating failure detector.
`timescale 1ns / 1ps
package hfd_pkg;
    localparam int MIN_RUN = 11;
    localparam int LEVEL_CHECK_LIMIT = 10;

    localparam logic [1:0] LVL_HEAT = 2'd1;
    localparam logic [1:0] LVL_HOLD = 2'd2;
    localparam logic [1:0] LVL_COOL = 2'd3;

    localparam logic [2:0] REG_FAIL_ENABLE = 3'd0;
    localparam logic [2:0] REG_MIN_TARGET  = 3'd1;
    localparam logic [2:0] REG_NEAR_BAND   = 3'd2;
    localparam logic [2:0] REG_HEAT_BAND   = 3'd3;
    localparam logic [2:0] REG_COOL_BAND   = 3'd4;
    localparam logic [2:0] REG_MIN_RISE    = 3'd5;
    localparam logic [2:0] REG_STRIKES     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_ACC_RD,
        ST_ACC,
        ST_MEAN,
        ST_DIV,
        ST_SCALE,
        ST_SDIV,
        ST_JUDGE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       fail_enable;
        logic [9:0] min_active_target;
        logic [5:0] near_band;
        logic [9:0] heating_band;
        logic [9:0] cooling_band;
        logic [5:0] min_rise;
        logic [1:0] strikes_to_fail;
    } t_cfg;
endpackage

@@ rtl/core/heating_failure_detector.sv @@
// Top level: heating failure detector with list memory and evaluation sequencer.
// A sample that does not complete the list goes straight to the result beat; one that
//   completes it goes through a run scan and, when a long heating run is checked, an
//   accumulate pass and three 24-step divisions on one serial divider.
// Throughput: one sample at a time; the next is taken once the result beat leaves.
// Reset: synchronous active-low; clears count, previous target, strikes, fault and result valid, loads defaults.
`timescale 1ns / 1ps
module heating_failure_detector
    import hfd_pkg::*;
#(
    parameter int LIST_SIZE = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [9:0]  i_target_temp,
    input  logic signed [10:0] i_current_temp,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_heat_fail,
    output logic        o_fault_latched,
    output logic        o_check_done,
    output logic [5:0]  o_samples_held
);
    localparam int AW = $clog2(LIST_SIZE);
    localparam int CW = $clog2(LIST_SIZE + 1);

    t_cfg r_cfg;
    logic [2:0] w_reg;
    assign w_reg  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_enable       <= 1'b1;
            r_cfg.min_active_target <= 10'd50;
            r_cfg.near_band         <= 6'd2;
            r_cfg.heating_band      <= 10'd20;
            r_cfg.cooling_band      <= 10'd10;
            r_cfg.min_rise          <= 6'd2;
            r_cfg.strikes_to_fail   <= 2'd2;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_FAIL_ENABLE: r_cfg.fail_enable       <= pwdata[0];
                REG_MIN_TARGET:  r_cfg.min_active_target <= pwdata[9:0];
                REG_NEAR_BAND:   r_cfg.near_band         <= pwdata[5:0];
                REG_HEAT_BAND:   r_cfg.heating_band      <= pwdata[9:0];
                REG_COOL_BAND:   r_cfg.cooling_band      <= pwdata[9:0];
                REG_MIN_RISE:    r_cfg.min_rise          <= pwdata[5:0];
                REG_STRIKES:     r_cfg.strikes_to_fail   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_FAIL_ENABLE: prdata = {31'd0, r_cfg.fail_enable};
            REG_MIN_TARGET:  prdata = {22'd0, r_cfg.min_active_target};
            REG_NEAR_BAND:   prdata = {26'd0, r_cfg.near_band};
            REG_HEAT_BAND:   prdata = {22'd0, r_cfg.heating_band};
            REG_COOL_BAND:   prdata = {22'd0, r_cfg.cooling_band};
            REG_MIN_RISE:    prdata = {26'd0, r_cfg.min_rise};
            REG_STRIKES:     prdata = {30'd0, r_cfg.strikes_to_fail};
            default:         prdata = '0;
        endcase
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [9:0]  r_prev;
    logic [1:0]  r_strikes;
    logic        r_fault;
    logic [9:0]  r_tgt;
    logic signed [10:0] r_cur;
    logic [1:0]  r_lead;
    logic [CW-1:0] r_run;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_half;
    logic signed [16:0] r_sum0, r_sum1;
    logic signed [10:0] r_hi0, r_lo0, r_hi1, r_lo1;
    logic signed [23:0] r_val;
    logic        r_phase;
    logic        r_fail;
    logic        r_done;
    logic        r_ovalid;
    logic [1:0]  r_last_lvl;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [10:0] temp_rd;
    logic [1:0]  lvl_rd;

    logic signed [11:0] w_err;
    logic [10:0] w_mag;
    logic [1:0]  w_level;

    hfd_ram #(.WIDTH(11), .DEPTH(LIST_SIZE)) u_temps (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(r_cur), .o_rdata(temp_rd));
    hfd_ram #(.WIDTH(2), .DEPTH(LIST_SIZE)) u_levels (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(w_level), .o_rdata(lvl_rd));

    logic        div_start, div_done;
    logic signed [23:0] div_num, div_quo;
    logic [5:0]  div_den;
    hfd_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(div_quo));

    assign w_err = $signed({2'b00, r_tgt}) - $signed({r_cur[10], r_cur});
    assign w_mag = w_err[11] ? 11'(-w_err) : w_err[10:0];
    always_comb begin
        if (w_err > $signed({2'b00, r_cfg.heating_band}))       w_level = LVL_HEAT;
        else if (w_err > -$signed({2'b00, r_cfg.cooling_band})) w_level = LVL_HOLD;
        else                                                    w_level = LVL_COOL;
    end

    logic w_clr_a, w_clr_b, w_store;
    assign w_clr_a = (r_tgt < r_cfg.min_active_target) || (w_mag < {5'd0, r_cfg.near_band});
    assign w_clr_b = !w_clr_a && (r_prev != r_tgt);
    assign w_store = !w_clr_a && !w_clr_b && (w_level != LVL_COOL)
        && !((r_count != '0) && (r_count < CW'(LEVEL_CHECK_LIMIT))
             && (w_level != r_last_lvl));

    assign o_stall  = (r_state != ST_IDLE) || r_ovalid;
    assign ram_we   = (r_state == ST_RUN_RD) && w_store;
    assign o_valid  = r_ovalid;

    logic w_in_first, w_in_second;
    logic [CW-1:0] w_rd_idx;
    assign w_rd_idx    = r_idx - CW'(1);
    assign w_in_first  = w_rd_idx < r_half;
    assign w_in_second = !w_in_first && (w_rd_idx < CW'(r_half << 1));

    always_comb begin
        ram_addr = AW'(r_idx);
        if (r_state == ST_RUN_RD) ram_addr = AW'(r_count);
    end

    logic signed [23:0] w_mean_num;
    assign w_mean_num = r_phase ? 24'(r_sum1 - r_hi1 - r_lo1) : 24'(r_sum0 - r_hi0 - r_lo0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_valid && !o_stall) n_state = ST_RUN_RD;
            ST_RUN_RD:  n_state = (ram_we && (r_count == CW'(LIST_SIZE - 1)))
                                  ? ST_RUN_CHK : ST_OUT;
            ST_RUN_CHK: n_state = (r_idx == CW'(LIST_SIZE)) ? ST_ACC_RD : ST_RUN_CHK;
            ST_ACC_RD:  n_state = ((r_run < CW'(MIN_RUN)) || (r_lead != LVL_HEAT))
                                  ? ST_OUT : ST_ACC;
            ST_ACC:     n_state = (r_idx == CW'(LIST_SIZE)) ? ST_MEAN : ST_ACC;
            ST_MEAN:    n_state = ST_DIV;
            ST_DIV:     if (div_done) n_state = r_phase ? ST_SCALE : ST_MEAN;
            ST_SCALE:   n_state = ST_SDIV;
            ST_SDIV:    if (div_done) n_state = ST_JUDGE;
            ST_JUDGE:   n_state = ST_OUT;
            ST_OUT:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = w_mean_num;
        div_den   = 6'(r_half - CW'(2));
        unique case (r_state)
            ST_MEAN:  div_start = 1'b1;
            ST_SCALE: begin
                div_start = 1'b1;
                div_num   = r_val * 24'(LIST_SIZE);
                div_den   = 6'(r_run);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_prev   <= '0;
            r_strikes <= '0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_tgt  <= i_target_temp;
                    r_cur  <= i_current_temp;
                end
                ST_RUN_RD: begin
                    r_fail <= 1'b0;
                    r_done <= 1'b0;
                    if (w_clr_b) r_prev <= r_tgt;
                    if (ram_we) begin
                        r_last_lvl <= w_level;
                        r_count    <= r_count + CW'(1);
                    end else begin
                        r_count <= '0;
                    end
                    if (ram_we && (r_count == CW'(LIST_SIZE - 1))) begin
                        r_idx <= '0;
                        r_run <= '0;
                        r_phase <= 1'b1;
                    end
                end
                ST_RUN_CHK: begin
                    if (r_idx == CW'(1)) r_lead <= lvl_rd;
                    if (r_idx != '0) begin
                        if (r_phase && ((r_idx == CW'(1)) || (lvl_rd == r_lead)))
                            r_run <= r_run + CW'(1);
                        else
                            r_phase <= 1'b0;
                    end
                    r_idx <= r_idx + CW'(1);
                end
                ST_ACC_RD: begin
                    r_idx  <= '0;
                    r_half <= r_run >> 1;
                    r_sum0 <= '0;
                    r_sum1 <= '0;
                end
                ST_ACC: begin
                    if (r_idx != '0) begin
                        if (w_in_first) begin
                            r_sum0 <= r_sum0 + 17'($signed(temp_rd));
                            if (w_rd_idx == '0 || $signed(temp_rd) > r_hi0) r_hi0 <= temp_rd;
                            if (w_rd_idx == '0 || $signed(temp_rd) < r_lo0) r_lo0 <= temp_rd;
                        end else if (w_in_second) begin
                            r_sum1 <= r_sum1 + 17'($signed(temp_rd));
                            if (w_rd_idx == r_half || $signed(temp_rd) > r_hi1)
                                r_hi1 <= temp_rd;
                            if (w_rd_idx == r_half || $signed(temp_rd) < r_lo1)
                                r_lo1 <= temp_rd;
                        end
                    end
                    r_idx <= r_idx + CW'(1);
                    r_phase <= 1'b0;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (!r_phase) r_val <= div_quo;
                        else r_val <= div_quo - r_val;
                        r_phase <= 1'b1;
                    end
                end
                ST_SDIV:  if (div_done) r_val <= div_quo;
                ST_JUDGE: begin
                    if (r_val < $signed({18'd0, r_cfg.min_rise})) begin
                        if ((r_strikes + 2'd1) >= r_cfg.strikes_to_fail) begin
                            r_strikes <= '0;
                            if (r_cfg.fail_enable) begin
                                r_fault <= 1'b1;
                                r_fail  <= 1'b1;
                            end
                        end else begin
                            r_strikes <= r_strikes + 2'd1;
                        end
                    end else begin
                        r_strikes <= '0;
                    end
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    if (r_count == CW'(LIST_SIZE)) begin
                        r_done  <= 1'b1;
                        r_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_heat_fail     = r_fail;
    assign o_fault_latched = r_fault;
    assign o_check_done    = r_done;
    assign o_samples_held  = 6'(r_count);

    a_idle_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ovalid && r_state != ST_IDLE))
        else $error("result beat pending while busy");
    a_fail_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_heat_fail && !o_fault_latched))
        else $error("fail without latched fault");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_samples_held > 6'(LIST_SIZE - 1)))
        else $error("list count out of range");
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable({o_heat_fail, o_fault_latched,
                                                      o_check_done, o_samples_held})))
        else $error("stalled result beat changed");
endmodule

@@ rtl/core/hfd_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module hfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/core/hfd_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module hfd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [23:0] i_num,
    input  logic [5:0]         i_den,
    output logic               o_done,
    output logic signed [23:0] o_quo
);
    logic [23:0] r_rem_num;
    logic [23:0] r_quo;
    logic [5:0]  r_rem;
    logic [5:0]  r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [6:0]  n_trial;
    logic [23:0] w_abs;

    assign w_abs   = i_num[23] ? 24'(-i_num) : i_num;
    assign n_trial = {r_rem, r_rem_num[23]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= 5'd0;
                r_rem     <= '0;
                r_rem_num <= w_abs;
                r_den     <= i_den;
                r_neg     <= i_num[23];
                r_quo     <= '0;
            end else if (r_busy) begin
                r_rem_num <= {r_rem_num[22:0], 1'b0};
                if (n_trial >= {1'b0, r_den}) begin
                    r_rem <= 6'(n_trial - {1'b0, r_den});
                    r_quo <= {r_quo[22:0], 1'b1};
                end else begin
                    r_rem <= n_trial[5:0];
                    r_quo <= {r_quo[22:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? 24'(-r_quo) : r_quo;
endmodule
